[hdl/acsc_pkg.sv]
package acsc_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_BTN_A = 2'd1;
	localparam logic [1:0] FUNC_BTN_B = 2'd2;

	localparam logic [1:0] CFG_BUTTON_GUARD = 2'd0;
	localparam logic [1:0] CFG_SWITCH_GUARD = 2'd1;

	localparam logic [7:0] BUTTON_GUARD_RST = 8'd3;
	localparam logic [7:0] SWITCH_GUARD_RST = 8'd30;
	localparam logic [7:0] TICK_LIMIT       = 8'd200;
	localparam logic [4:0] FIRST_DIGIT_WRAP = 5'd3;
	localparam logic [4:0] DIGIT_WRAP       = 5'd10;
	localparam logic [6:0] ALARM_HOUR_RST   = 7'd18;
	localparam logic [6:0] ALARM_MIN_RST    = 7'd5;

	// floor(x / 10) == (x * 205) >> 11 for x < 1029
	localparam logic [14:0] DIV10_MUL   = 15'd205;
	localparam int          DIV10_SHIFT = 11;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] rtc_hours;
		logic [5:0] rtc_minutes;
		logic       alarm_switch;
	} item_t;

	typedef struct packed {
		logic [3:0] digit_h_tens;
		logic [3:0] digit_h_ones;
		logic [3:0] digit_m_tens;
		logic [3:0] digit_m_ones;
		logic [1:0] blink_position;
		logic       setup_active;
		logic       alarm_led;
		logic       buzzer_on;
		logic       time_write;
		logic [6:0] write_hours;
		logic [6:0] write_minutes;
		logic       display_refresh;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	function automatic digits_t split_dec(input logic [6:0] x);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		digits_t     d;
		prod   = 15'(x) * DIV10_MUL;
		q      = prod[DIV10_SHIFT +: 4];
		r      = x - 7'({q, 3'b000} + {q, 1'b0});
		d.tens = q;
		d.ones = r[3:0];
		return d;
	endfunction

	function automatic logic [6:0] join_dec(input logic [3:0] tens, input logic [3:0] ones);
		logic [7:0] s;
		s = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
		return s[6:0];
	endfunction

endpackage

[hdl/alarm_clock_setup_controller_unit.sv]
// Alarm clock setup-mode controller.
// Input channel (in_valid/in_ready): one event per transaction - a tick with
// the clock time and alarm switch level, button A or button B (func).
// Output channel (out_valid/out_ready): exactly one result per event, in
// order: displayed digits, edit position, setup/alarm/buzzer flags, clock
// write request and display refresh.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// button guard, index 1 switch guard; always ready, write only when idle.
// Pipeline: input register, then result register. Throughput: one event per
// cycle while out_ready is high, the mode logic being a single combinational
// pass between the two registers.
// Reset (arst_n low): guards 3 and 30, alarm time 18:05, setup, alarm and
// ringing off, no result pending.
// Receiver stall: the result register holds; one further event waits in the
// input register, after which in_ready drops until out_ready returns.
module alarm_clock_setup_controller_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [4:0] rtc_hours,
	input  logic [5:0] rtc_minutes,
	input  logic       alarm_switch,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] digit_h_tens,
	output logic [3:0] digit_h_ones,
	output logic [3:0] digit_m_tens,
	output logic [3:0] digit_m_ones,
	output logic [1:0] blink_position,
	output logic       setup_active,
	output logic       alarm_led,
	output logic       buzzer_on,
	output logic       time_write,
	output logic [6:0] write_hours,
	output logic [6:0] write_minutes,
	output logic       display_refresh,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import acsc_pkg::*;

	item_t   item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	cfg_wr_t cfg;
	result_t res_d;
	result_t res_q;

	assign item.func         = func;
	assign item.rtc_hours    = rtc_hours;
	assign item.rtc_minutes  = rtc_minutes;
	assign item.alarm_switch = alarm_switch;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	acsc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	acsc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item_s1 (item_s1),
		.res_d   (res_d)
	);

	acsc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.out_ready (out_ready),
		.res_d     (res_d),
		.advance   (advance),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign digit_h_tens    = res_q.digit_h_tens;
	assign digit_h_ones    = res_q.digit_h_ones;
	assign digit_m_tens    = res_q.digit_m_tens;
	assign digit_m_ones    = res_q.digit_m_ones;
	assign blink_position  = res_q.blink_position;
	assign setup_active    = res_q.setup_active;
	assign alarm_led       = res_q.alarm_led;
	assign buzzer_on       = res_q.buzzer_on;
	assign time_write      = res_q.time_write;
	assign write_hours     = res_q.write_hours;
	assign write_minutes   = res_q.write_minutes;
	assign display_refresh = res_q.display_refresh;
endmodule

[hdl/acsc_in_reg.sv]
module acsc_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  acsc_pkg::item_t  item,
	input  logic             advance,
	output logic             valid_s1,
	output acsc_pkg::item_t  item_s1
);
	import acsc_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end
endmodule

[hdl/acsc_core.sv]
module acsc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  acsc_pkg::cfg_wr_t  cfg,
	input  logic               advance,
	input  acsc_pkg::item_t    item_s1,
	output acsc_pkg::result_t  res_d
);
	import acsc_pkg::*;

	logic [7:0] button_guard_q;
	logic [7:0] switch_guard_q;
	logic [7:0] tick_q;
	logic       setup_q;
	logic       enabled_q;
	logic       ringing_q;
	logic [1:0] pos_q;
	logic [3:0] digits_q [4];
	logic [6:0] alarm_hr_q;
	logic [6:0] alarm_min_q;
	logic [5:0] last_min_q;

	logic [7:0] tick_d;
	logic       setup_d;
	logic       enabled_d;
	logic       ringing_d;
	logic [1:0] pos_d;
	logic [3:0] digits_d [4];
	logic [6:0] alarm_hr_d;
	logic [6:0] alarm_min_d;
	logic [5:0] last_min_d;

	logic       twrite;
	logic [6:0] wr_h;
	logic [6:0] wr_m;
	logic       refresh;
	logic       btn_ok;
	logic [6:0] load_hi;
	logic [6:0] load_lo;
	digits_t    load_h;
	digits_t    load_m;
	digits_t    rtc_h;
	digits_t    rtc_m;
	logic [4:0] inc;
	logic [4:0] lim;
	logic [6:0] join_h;
	logic [6:0] join_m;

	assign load_hi = enabled_q ? alarm_hr_q : {2'b00, item_s1.rtc_hours};
	assign load_lo = enabled_q ? alarm_min_q : {1'b0, item_s1.rtc_minutes};
	assign load_h  = split_dec(load_hi);
	assign load_m  = split_dec(load_lo);
	assign rtc_h   = split_dec({2'b00, item_s1.rtc_hours});
	assign rtc_m   = split_dec({1'b0, item_s1.rtc_minutes});
	assign join_h  = join_dec(digits_q[0], digits_q[1]);
	assign join_m  = join_dec(digits_q[2], digits_q[3]);
	assign btn_ok  = tick_q > button_guard_q;
	assign inc     = {1'b0, digits_q[pos_q]} + 5'd1;
	assign lim     = (pos_q == 2'd0) ? FIRST_DIGIT_WRAP : DIGIT_WRAP;

	always_comb begin
		tick_d      = tick_q;
		setup_d     = setup_q;
		enabled_d   = enabled_q;
		ringing_d   = ringing_q;
		pos_d       = pos_q;
		digits_d    = digits_q;
		alarm_hr_d  = alarm_hr_q;
		alarm_min_d = alarm_min_q;
		last_min_d  = last_min_q;
		twrite      = 1'b0;
		wr_h        = '0;
		wr_m        = '0;
		refresh     = 1'b0;
		case (item_s1.func) inside
			FUNC_TICK: begin
				if (item_s1.alarm_switch && tick_q > switch_guard_q) begin
					enabled_d = !enabled_q;
					if (enabled_q) begin
						ringing_d = 1'b0;
					end
				end
				if (setup_q) begin
					refresh = 1'b1;
				end else begin
					if (enabled_d && {1'b0, item_s1.rtc_minutes} == alarm_min_q &&
							{2'b00, item_s1.rtc_hours} == alarm_hr_q) begin
						ringing_d = 1'b1;
					end
					if (item_s1.rtc_minutes != last_min_q) begin
						refresh    = 1'b1;
						last_min_d = item_s1.rtc_minutes;
					end
				end
				if (tick_q < TICK_LIMIT) begin
					tick_d = tick_q + 8'd1;
				end
			end
			FUNC_BTN_A, FUNC_BTN_B: begin
				if (item_s1.func == FUNC_BTN_A && btn_ok) begin
					if (!setup_q) begin
						setup_d     = 1'b1;
						digits_d[0] = load_h.tens;
						digits_d[1] = load_h.ones;
						digits_d[2] = load_m.tens;
						digits_d[3] = load_m.ones;
					end else if (pos_q == 2'd3) begin
						if (enabled_q) begin
							alarm_hr_d  = join_h;
							alarm_min_d = join_m;
						end else begin
							twrite = 1'b1;
							wr_h   = join_h;
							wr_m   = join_m;
						end
						pos_d   = 2'd0;
						setup_d = 1'b0;
					end else begin
						pos_d = pos_q + 2'd1;
					end
				end else if (item_s1.func == FUNC_BTN_B && btn_ok && setup_q) begin
					digits_d[pos_q] = (inc >= lim) ? 4'd0 : inc[3:0];
				end
				tick_d  = '0;
				refresh = setup_d || twrite;
			end
			default: begin
				refresh = setup_q;
			end
		endcase
	end

	always_comb begin
		if (setup_d) begin
			res_d.digit_h_tens = digits_d[0];
			res_d.digit_h_ones = digits_d[1];
			res_d.digit_m_tens = digits_d[2];
			res_d.digit_m_ones = digits_d[3];
		end else begin
			res_d.digit_h_tens = rtc_h.tens;
			res_d.digit_h_ones = rtc_h.ones;
			res_d.digit_m_tens = rtc_m.tens;
			res_d.digit_m_ones = rtc_m.ones;
		end
		res_d.blink_position  = pos_d;
		res_d.setup_active    = setup_d;
		res_d.alarm_led       = enabled_d;
		res_d.buzzer_on       = ringing_d;
		res_d.time_write      = twrite;
		res_d.write_hours     = wr_h;
		res_d.write_minutes   = wr_m;
		res_d.display_refresh = refresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_guard_q <= BUTTON_GUARD_RST;
			switch_guard_q <= SWITCH_GUARD_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_BUTTON_GUARD) begin
				button_guard_q <= cfg.data;
			end else if (cfg.index == CFG_SWITCH_GUARD) begin
				switch_guard_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			setup_q     <= 1'b0;
			enabled_q   <= 1'b0;
			ringing_q   <= 1'b0;
			pos_q       <= '0;
			digits_q    <= '{default: '0};
			alarm_hr_q  <= ALARM_HOUR_RST;
			alarm_min_q <= ALARM_MIN_RST;
			last_min_q  <= '0;
		end else if (advance) begin
			tick_q      <= tick_d;
			setup_q     <= setup_d;
			enabled_q   <= enabled_d;
			ringing_q   <= ringing_d;
			pos_q       <= pos_d;
			digits_q    <= digits_d;
			alarm_hr_q  <= alarm_hr_d;
			alarm_min_q <= alarm_min_d;
			last_min_q  <= last_min_d;
		end
	end
endmodule

[hdl/acsc_out_reg.sv]
module acsc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic               out_ready,
	input  acsc_pkg::result_t  res_d,
	output logic               advance,
	output logic               out_valid,
	output acsc_pkg::result_t  res_q
);
	import acsc_pkg::*;

	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end
endmodule

[hdl/acsc_checker.sv]
module acsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] blink_position,
	input logic       setup_active,
	input logic       alarm_led,
	input logic       buzzer_on,
	input logic       time_write,
	input logic [6:0] write_hours,
	input logic [6:0] write_minutes
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_hours) &&
			$stable(write_minutes) && $stable(blink_position))
		else $error("result changed while stalled");

	a_ring_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && buzzer_on |-> alarm_led)
		else $error("buzzer on with alarm disabled");

	a_write_leaves_setup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_write |-> !setup_active && blink_position == 2'd0)
		else $error("clock write while still in setup");

	a_write_fields_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !time_write |-> write_hours == 7'd0 && write_minutes == 7'd0)
		else $error("write fields set without a write request");

	a_position_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !setup_active |-> blink_position == 2'd0)
		else $error("edit position moved outside setup");
endmodule

bind alarm_clock_setup_controller_unit acsc_checker u_acsc_checker (.*);
